/* rtl/contiguous_first_fit_allocator_assert.svh */
// Assertion helpers for the allocator
`ifndef CONTIGUOUS_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_FIRST_FIT_ALLOCATOR_ASSERT_SVH

// Implication checked at every clock edge outside reset
`define CFFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define CFFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cffa_pkg.sv */
package cffa_pkg;

  localparam int unsigned DEF_DISK_BLOCKS = 256;
  localparam int unsigned DEF_MAX_FILES   = 16;
  localparam logic [8:0]  DISK_SIZE_RST   = 9'd256;

  // Request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EXISTS   = 3'd1;
  localparam logic [2:0] ST_NOSPACE  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_DONE
  } state_e;

endpackage

/* rtl/cffa_cell.sv */
// One ring cell: loads its neighbor's word when the ring advances
module cffa_cell import cffa_pkg::*; #(
  parameter int unsigned W = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         shift_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (shift_i) begin
      word_q <= d_i;
    end
  end

  assign q_o = word_q;

endmodule

/* rtl/contiguous_first_fit_allocator.sv */
// Each request runs one search lap and one update lap of the rings, then its result
// goes into the output register, which raises out_valid_o; every request takes both
// laps. A request is taken only when idle, so the next one waits until the result
// of the previous one has been loaded into the output register.
// Reset: asynchronous, active low; all blocks free, table empty, disk_size 256.
module contiguous_first_fit_allocator import cffa_pkg::*; #(
  parameter int unsigned DISK_BLOCKS = DEF_DISK_BLOCKS,
  parameter int unsigned MAX_FILES   = DEF_MAX_FILES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [8:0] cfg_disk_size_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       op_i,
  input  logic [7:0] file_id_i,
  input  logic [8:0] length_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [7:0] start_block_o,
  output logic [8:0] run_length_o
);

  `include "contiguous_first_fit_allocator_assert.svh"

  localparam int unsigned P  = (DISK_BLOCKS > MAX_FILES) ? DISK_BLOCKS : MAX_FILES;
  localparam int unsigned CW = $clog2(P);
  localparam int unsigned BW = $clog2(DISK_BLOCKS);
  localparam int unsigned IW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int unsigned XW = ((CW > 9) ? CW : 9) + 2;
  localparam int unsigned TW = 1 + 8 + BW + 9;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q;
  logic          last_lap;
  logic [8:0]    disk_q;

  // Request capture
  logic       op_q;
  logic [7:0] id_q;
  logic [8:0] len_q;

  // Search results
  logic          found_q, free_ok_q, fit_q;
  logic [IW-1:0] found_k_q, free_k_q;
  logic [BW-1:0] fit_start_q, hit_start_q;
  logic [8:0]    hit_len_q;
  logic [9:0]    run_q;

  // Output register
  logic       out_valid_q;
  logic [2:0] status_q;
  logic [7:0] start_q;
  logic [8:0] rlen_q;

  // Rings
  logic [DISK_BLOCKS-1:0] bm_q;
  logic                   bm_head_d;
  logic [TW-1:0]          tb_q [MAX_FILES];
  logic [TW-1:0]          tb_head_d;
  logic                   bm_shift, tb_shift, busy;

  logic          hd_valid;
  logic [7:0]    hd_id;
  logic [BW-1:0] hd_start;
  logic [8:0]    hd_len;
  logic [XW-1:0] cnt_x, run_end, fit_new;
  logic [IW-1:0] slot;
  logic          in_limit, in_range, in_take, out_load;
  logic [2:0]    res_status;

  assign busy      = (state_q == ST_SCAN) || (state_q == ST_COMMIT);
  assign last_lap  = (cnt_q == CW'(P - 1));
  assign cnt_x     = XW'(cnt_q);
  assign bm_shift  = busy && (cnt_x < XW'(DISK_BLOCKS));
  assign tb_shift  = busy && (cnt_x < XW'(MAX_FILES));
  assign slot      = IW'(cnt_q);
  assign {hd_valid, hd_id, hd_start, hd_len} = tb_q[0];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Block ring
  for (genvar j = 0; j < DISK_BLOCKS; j++) begin : g_bm
    cffa_cell #(.W(1)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(bm_shift),
      .d_i    ((j == DISK_BLOCKS - 1) ? bm_head_d : bm_q[(j + 1) % DISK_BLOCKS]),
      .q_o    (bm_q[j])
    );
  end

  // File table ring
  for (genvar j = 0; j < MAX_FILES; j++) begin : g_tb
    cffa_cell #(.W(TW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(tb_shift),
      .d_i    ((j == MAX_FILES - 1) ? tb_head_d : tb_q[(j + 1) % MAX_FILES]),
      .q_o    (tb_q[j])
    );
  end

  // Head updates: unchanged during search, written during commit of a good request
  assign in_limit = (cnt_x < XW'(disk_q));
  assign run_end  = (op_q == OP_ALLOC) ? (XW'(fit_start_q) + XW'(len_q))
                                       : (XW'(hit_start_q) + XW'(hit_len_q));
  assign in_range = (cnt_x >= ((op_q == OP_ALLOC) ? XW'(fit_start_q) : XW'(hit_start_q)))
                    && (cnt_x < run_end);
  assign fit_new  = cnt_x + XW'(1) - XW'(len_q);

  always_comb begin
    bm_head_d = bm_q[0];
    tb_head_d = tb_q[0];
    if (state_q == ST_COMMIT && res_status == ST_OK) begin
      if (in_range) begin
        bm_head_d = (op_q == OP_ALLOC);
      end
      if (op_q == OP_ALLOC && slot == free_k_q) begin
        tb_head_d = {1'b1, id_q, fit_start_q, len_q};
      end else if (op_q == OP_FREE && slot == found_k_q) begin
        tb_head_d = {1'b0, hd_id, hd_start, hd_len};
      end
    end
  end

  // Result of the search lap
  always_comb begin
    res_status = ST_OK;
    if (op_q == OP_ALLOC) begin
      priority if (found_q) begin
        res_status = ST_EXISTS;
      end else if (!fit_q) begin
        res_status = ST_NOSPACE;
      end else if (!free_ok_q) begin
        res_status = ST_FULL;
      end else begin
        res_status = ST_OK;
      end
    end else if (!found_q) begin
      res_status = ST_NOTFOUND;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_take) state_d = ST_SCAN;
      ST_SCAN:   if (last_lap) state_d = ST_COMMIT;
      ST_COMMIT: if (last_lap) state_d = ST_DONE;
      ST_DONE:   if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer and search bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      disk_q    <= DISK_SIZE_RST;
      found_q   <= 1'b0;
      free_ok_q <= 1'b0;
      fit_q     <= 1'b0;
      run_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        disk_q <= cfg_disk_size_i;
      end
      state_q <= state_d;
      cnt_q <= (busy && !last_lap) ? cnt_q + CW'(1) : '0;
      if (in_take) begin
        found_q   <= 1'b0;
        free_ok_q <= 1'b0;
        fit_q     <= 1'b0;
        run_q     <= '0;
      end else if (state_q == ST_SCAN) begin
        if (tb_shift) begin
          if (hd_valid && hd_id == id_q && !found_q) found_q <= 1'b1;
          if (!hd_valid && !free_ok_q) free_ok_q <= 1'b1;
        end
        if (bm_shift && in_limit) begin
          run_q <= bm_q[0] ? '0 : run_q + 10'd1;
          if (!bm_q[0] && !fit_q && (run_q + 10'd1 == {1'b0, len_q})) fit_q <= 1'b1;
        end
      end
    end
  end

  // Payload captured on acceptance; match and fit details captured during the search lap
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q  <= op_i;
      id_q  <= file_id_i;
      len_q <= length_i;
    end else if (state_q == ST_SCAN) begin
      if (tb_shift && hd_valid && hd_id == id_q && !found_q) begin
        found_k_q   <= slot;
        hit_start_q <= hd_start;
        hit_len_q   <= hd_len;
      end
      if (tb_shift && !hd_valid && !free_ok_q) free_k_q <= slot;
      if (bm_shift && in_limit && !bm_q[0] && !fit_q
          && (run_q + 10'd1 == {1'b0, len_q})) begin
        fit_start_q <= BW'(fit_new);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= res_status;
      start_q  <= '0;
      rlen_q   <= '0;
      if (res_status == ST_OK) begin
        start_q <= (op_q == OP_ALLOC) ? 8'(fit_start_q) : 8'(hit_start_q);
        rlen_q  <= (op_q == OP_ALLOC) ? len_q : hit_len_q;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign start_block_o = start_q;
  assign run_length_o  = rlen_q;

  // Checks
  `CFFA_ASSERT_NEXT(a_take_scan, in_take, state_q == ST_SCAN, "request did not start a search")
  `CFFA_ASSERT_IMP(a_ok_len, out_valid_o, (status_o == ST_OK) == (run_length_o != 9'd0), "bad len")
  `CFFA_ASSERT_NEXT(a_hold_out, out_valid_o && out_stall_i, out_valid_o && $stable(status_o), "lost")
  `CFFA_ASSERT_IMP(a_idle_cnt, state_q == ST_IDLE || state_q == ST_DONE, cnt_q == '0, "cnt busy")

endmodule
